[hw/rtl/sorted_priority_queue_assert.svh]
// Assertion helpers for the sorted priority queue.
// With SYNTH defined every helper expands to nothing.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spq assertion failed");

`else

`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [2:0] LEVEL_MAX = 3'd5;
   localparam logic [6:0] AGE_MAX   = 7'd110;
   localparam logic [2:0] LEVEL_MIN = 3'd1;
   localparam logic [6:0] AGE_MIN   = 7'd1;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_CALL   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_EMPTY   = 2'd1,
      ST_FULL    = 2'd2,
      ST_INVALID = 2'd3
   } status_code_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_CALL   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_RESP = 2'd2
   } state_type;

   typedef struct packed {
      logic [15:0] tag;
      logic [2:0]  level;
      logic [6:0]  age;
   } entry_type;

   // controller -> datapath
   typedef struct packed {
      logic            capture;
      logic            execute;
      action_type      action;
      status_code_type code;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      op_type opcode;
      logic   req_ok;
      logic   empty;
      logic   full;
   } ctrl_stat_type;

endpackage

`default_nettype wire

[hw/rtl/spq_if.sv]
`default_nettype none

interface spq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] entry_tag;
   logic [2:0]  priority_level;
   logic [6:0]  age_years;

   modport source (output valid, opcode, entry_tag, priority_level, age_years,
                   input ready);
   modport sink   (input valid, opcode, entry_tag, priority_level, age_years,
                   output ready);
endinterface

interface spq_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] out_tag;
   logic [2:0]  out_priority;
   logic [6:0]  out_age;
   logic [4:0]  entry_count;

   modport source (output valid, status, out_tag, out_priority, out_age, entry_count,
                   input ready);
   modport sink   (input valid, status, out_tag, out_priority, out_age, entry_count,
                   output ready);
endinterface

`default_nettype wire

[hw/rtl/spq_datapath.sv]
`default_nettype none

module spq_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spq_pkg::ctrl_cmd_type cmd,
   output spq_pkg::ctrl_stat_type    stat,
   input  wire logic [1:0]           req_opcode,
   input  wire logic [15:0]          req_entry_tag,
   input  wire logic [2:0]           req_priority_level,
   input  wire logic [6:0]           req_age_years,
   output logic [1:0]                rsp_status,
   output logic [15:0]               rsp_out_tag,
   output logic [2:0]                rsp_out_priority,
   output logic [6:0]                rsp_out_age,
   output logic [4:0]                rsp_entry_count
);
   import spq_pkg::*;

   op_type          op_ff;
   entry_type       new_ff;
   entry_type       cells_ff [CAPACITY];
   entry_type       cells_in [CAPACITY];
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CAPACITY-1:0] at_or_after;

   status_code_type status_ff;
   entry_type       out_ff;
   logic [4:0]      out_count_ff;

   // request hold
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff        <= op_type'(req_opcode);
         new_ff.tag   <= req_entry_tag;
         new_ff.level <= req_priority_level;
         new_ff.age   <= req_age_years;
      end
   end

   always_comb begin
      stat.opcode = op_ff;
      stat.req_ok = (new_ff.level >= LEVEL_MIN) && (new_ff.level <= LEVEL_MAX) &&
                    (new_ff.age >= AGE_MIN) && (new_ff.age <= AGE_MAX);
      stat.empty  = (count_ff == '0);
      stat.full   = (count_ff >= CNT_W'(CAPACITY));
   end

   // each cell flags whether the new entry lands at or in front of it
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         at_or_after[i] = !(CNT_W'(i) < count_ff) || (cells_ff[i].level >= new_ff.level);
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
         if (cmd.execute && cmd.action == ACT_INSERT) begin
            if (i == 0) begin
               if (at_or_after[0]) cells_in[0] = new_ff;
            end else begin
               if (at_or_after[i-1])   cells_in[i] = cells_ff[i-1];
               else if (at_or_after[i]) cells_in[i] = new_ff;
            end
         end else if (cmd.execute && cmd.action == ACT_CALL) begin
            if (i < CAPACITY - 1) cells_in[i] = cells_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.execute) begin
         unique case (cmd.action)
            ACT_INSERT: count_in = count_ff + CNT_W'(1);
            ACT_CALL:   count_in = count_ff - CNT_W'(1);
            ACT_CLEAR:  count_in = '0;
            ACT_NONE:   count_in = count_ff;
            default:    count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         status_ff    <= cmd.code;
         out_ff       <= (cmd.action == ACT_CALL) ? cells_ff[0] : '0;
         out_count_ff <= 5'(count_in);
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_out_tag      = out_ff.tag;
   assign rsp_out_priority = out_ff.level;
   assign rsp_out_age      = out_ff.age;
   assign rsp_entry_count  = out_count_ff;

endmodule

`default_nettype wire

[hw/rtl/spq_ctrl.sv]
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire spq_pkg::ctrl_stat_type stat,
   output spq_pkg::ctrl_cmd_type      cmd
);
   import spq_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == S_IDLE);
      rsp_valid   = (state_ff == S_RESP);
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.execute = (state_ff == S_EXEC);
      cmd.action  = ACT_NONE;
      cmd.code    = ST_DONE;
      if (state_ff == S_EXEC) begin
         unique case (stat.opcode)
            OP_INSERT: begin
               // value check wins over the full check
               if (!stat.req_ok)  cmd.code = ST_INVALID;
               else if (stat.full) cmd.code = ST_FULL;
               else               cmd.action = ACT_INSERT;
            end
            OP_CALL: begin
               if (stat.empty) cmd.code = ST_EMPTY;
               else            cmd.action = ACT_CALL;
            end
            OP_CLEAR: begin
               if (stat.empty) cmd.code = ST_EMPTY;
               else            cmd.action = ACT_CLEAR;
            end
            OP_UNUSED: begin
               cmd.code = ST_INVALID;
            end
            default: cmd.code = ST_INVALID;
         endcase
      end
   end

   `SPQ_ASSERT_NEXT(a_capture_then_exec, clock, reset, cmd.capture, cmd.execute)
   `SPQ_ASSERT_NOW(a_no_insert_full, clock, reset, cmd.execute && cmd.action == ACT_INSERT, !stat.full)
   `SPQ_ASSERT_NOW(a_no_call_empty, clock, reset, cmd.execute && cmd.action == ACT_CALL, !stat.empty)
   `SPQ_ASSERT_NOW(a_action_means_done, clock, reset, cmd.action != ACT_NONE, cmd.code == ST_DONE)

endmodule

`default_nettype wire

[hw/rtl/sorted_priority_queue.sv]
// Sorted priority queue: holds up to spq_pkg::CAPACITY entries (tag, level, age) in
// ascending level order; insert places a new entry ahead of the first one whose level
// is equal or higher (ties come out newest first), call pops the head, clear empties.
// Each request word yields exactly one response word with a status code and the count.
// A word passes through S_IDLE, which accepts it, S_EXEC, where the cell array compares
// and shifts in place, and S_RESP, which presents the response; the controller handles
// one word at a time, and a stalled response holds off the next request.
`default_nettype none

module sorted_priority_queue (
   input wire logic clock,
   input wire logic reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);
   import spq_pkg::*;

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   // sequencing and result-code decisions
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // entry cells, count and response word
   spq_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_chan.opcode),
      .req_entry_tag      (req_chan.entry_tag),
      .req_priority_level (req_chan.priority_level),
      .req_age_years      (req_chan.age_years),
      .rsp_status         (rsp_chan.status),
      .rsp_out_tag        (rsp_chan.out_tag),
      .rsp_out_priority   (rsp_chan.out_priority),
      .rsp_out_age        (rsp_chan.out_age),
      .rsp_entry_count    (rsp_chan.entry_count)
   );

endmodule

`default_nettype wire
